// ===== rtl/eqs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqs_pkg: shared types and constants of the edge quantile selector
// Sample format, default register values and the controller state type.
// ----------------------------------------------------------------------------
package eqs_pkg;

    localparam int          DATA_W         = 32;
    localparam int          EDGE_W         = 16;
    localparam int          TOTAL_W        = 11;
    localparam int          MAX_SAMPLES    = 1024;
    localparam logic [15:0] EDGE_RESET     = 16'd1638;
    localparam logic [16:0] ONE_FRAC       = 17'h10000;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_POS,
        ST_RD_LO,
        ST_RD_LO1,
        ST_RD_HI,
        ST_RD_HI1,
        ST_MUL,
        ST_SUM,
        ST_OUT
    } t_state;

    // memory request from the controller
    typedef struct packed {
        logic        wr_en;
        logic [15:0] wr_addr;
        logic [31:0] wr_data;
        logic [15:0] rd_addr;
    } t_mem_req;

endpackage

// ===== rtl/eqs_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqs_stream_if: valid/ready channel
// Carries one request payload of parametric width.
// ----------------------------------------------------------------------------
interface eqs_stream_if #(
    parameter int WIDTH = 33
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/eqs_sample_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqs_sample_ram: sample store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module eqs_sample_ram #(
    parameter int DEPTH = eqs_pkg::MAX_SAMPLES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic [31:0]           i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output logic [31:0]           o_rdata
);
    logic [31:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/eqs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqs_ctrl: insertion sort and quantile sequencer
// Shifts the stored set up one entry a step to insert each sample, then
// reads the two neighbor pairs and interpolates.
// ----------------------------------------------------------------------------
module eqs_ctrl #(
    parameter int DEPTH = eqs_pkg::MAX_SAMPLES,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [15:0]       i_edge_frac,
    eqs_stream_if.sink        in_if,
    eqs_stream_if.source      out_if,
    output eqs_pkg::t_mem_req o_mem,
    input  logic [31:0]       i_rdata
);
    eqs_pkg::t_state r_state, n_state;
    logic [CW-1:0]        r_fill, n_fill;
    logic                 r_ovf, n_ovf;
    logic                 r_last, n_last;
    logic signed [31:0]   r_val, n_val;
    logic [CW-1:0]        r_idx, n_idx;
    logic [CW+15:0]       r_plo, n_plo, r_phi, n_phi;
    logic signed [31:0]   r_blo, n_blo, r_bhi, n_bhi;
    logic signed [32:0]   r_dlo, n_dlo, r_dhi, n_dhi;
    logic signed [49:0]   r_mlo, n_mlo, r_mhi, n_mhi;
    logic signed [31:0]   r_qlo, n_qlo, r_qhi, n_qhi;
    logic [75:0]          r_out, n_out;
    logic                 r_ovalid, n_ovalid;
    logic [CW-1:0]        w_span;
    logic [CW-1:0]        w_klo, w_khi;
    logic                 w_lo_one, w_hi_one;

    assign w_span = r_fill - CW'(1);

    // index into the store: integer part, clamped to n-1
    function automatic logic [CW-1:0] f_k(input logic [CW+15:0] p, input logic [CW-1:0] s);
        logic [CW-1:0] k;
        k = p[CW+15:16];
        return (k > s) ? s : k;
    endfunction

    assign w_klo = f_k(r_plo, w_span);
    assign w_khi = f_k(r_phi, w_span);
    assign w_lo_one = (r_plo[15:0] == 16'd0) || (w_klo >= w_span);
    assign w_hi_one = (r_phi[15:0] == 16'd0) || (w_khi >= w_span);

    // state and data registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= eqs_pkg::ST_IDLE;
            r_fill   <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_ovf    <= n_ovf;
            r_ovalid <= n_ovalid;
        end
        r_last <= n_last; r_val <= n_val; r_idx <= n_idx;
        r_plo <= n_plo; r_phi <= n_phi; r_blo <= n_blo; r_bhi <= n_bhi;
        r_dlo <= n_dlo; r_dhi <= n_dhi; r_mlo <= n_mlo; r_mhi <= n_mhi;
        r_qlo <= n_qlo; r_qhi <= n_qhi; r_out <= n_out;
    end

    assign in_if.ready  = (r_state == eqs_pkg::ST_IDLE);
    assign out_if.valid = r_ovalid;
    assign out_if.data  = r_out;

    // next state and memory control
    always_comb begin
        n_state = r_state; n_fill = r_fill; n_ovf = r_ovf; n_last = r_last;
        n_val = r_val; n_idx = r_idx; n_plo = r_plo; n_phi = r_phi;
        n_blo = r_blo; n_bhi = r_bhi; n_dlo = r_dlo; n_dhi = r_dhi;
        n_mlo = r_mlo; n_mhi = r_mhi; n_qlo = r_qlo; n_qhi = r_qhi;
        n_out = r_out; n_ovalid = r_ovalid;
        o_mem = '0;
        if (out_if.ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            eqs_pkg::ST_IDLE: begin
                if (in_if.valid) begin
                    n_val  = in_if.data[31:0];
                    n_last = in_if.data[32];
                    n_idx  = r_fill;
                    if (r_fill == CW'(DEPTH)) begin
                        n_ovf   = 1'b1;
                        n_state = eqs_pkg::ST_POS;
                    end else if (r_fill == '0) begin
                        n_state = eqs_pkg::ST_INS_CMP;
                    end else begin
                        n_state = eqs_pkg::ST_INS_RD;
                    end
                end
            end
            // read the entry below the hole
            eqs_pkg::ST_INS_RD: begin
                o_mem.rd_addr = 16'(r_idx - CW'(1));
                n_state = eqs_pkg::ST_INS_CMP;
            end
            // move it up, or drop the sample into the hole
            eqs_pkg::ST_INS_CMP: begin
                o_mem.wr_en = 1'b1;
                o_mem.wr_addr = 16'(r_idx);
                if (r_idx != '0 && $signed(i_rdata) > r_val) begin
                    o_mem.wr_data = i_rdata;
                    n_idx = r_idx - CW'(1);
                    n_state = (r_idx == CW'(1)) ? eqs_pkg::ST_INS_CMP
                                                : eqs_pkg::ST_INS_RD;
                end else begin
                    o_mem.wr_data = r_val;
                    n_fill = r_fill + CW'(1);
                    n_state = eqs_pkg::ST_POS;
                end
            end
            // positions of both quantiles
            eqs_pkg::ST_POS: begin
                if (!r_last) begin
                    n_state = eqs_pkg::ST_IDLE;
                end else begin
                    n_plo = (CW+16)'(i_edge_frac) * (CW+16)'(w_span);
                    n_phi = (CW+16)'(eqs_pkg::ONE_FRAC - 17'(i_edge_frac))
                            * (CW+16)'(w_span);
                    n_state = eqs_pkg::ST_RD_LO;
                end
            end
            eqs_pkg::ST_RD_LO: begin
                o_mem.rd_addr = 16'(w_klo);
                n_state = eqs_pkg::ST_RD_LO1;
            end
            eqs_pkg::ST_RD_LO1: begin
                n_blo = i_rdata;
                o_mem.rd_addr = 16'(w_lo_one ? w_klo : w_klo + CW'(1));
                n_state = eqs_pkg::ST_RD_HI;
            end
            eqs_pkg::ST_RD_HI: begin
                n_dlo = w_lo_one ? 33'sd0 : 33'($signed(i_rdata)) - 33'(r_blo);
                o_mem.rd_addr = 16'(w_khi);
                n_state = eqs_pkg::ST_RD_HI1;
            end
            eqs_pkg::ST_RD_HI1: begin
                n_bhi = i_rdata;
                o_mem.rd_addr = 16'(w_hi_one ? w_khi : w_khi + CW'(1));
                n_state = eqs_pkg::ST_MUL;
            end
            eqs_pkg::ST_MUL: begin
                n_dhi = w_hi_one ? 33'sd0 : 33'($signed(i_rdata)) - 33'(r_bhi);
                n_mlo = r_dlo * $signed({1'b0, r_plo[15:0]});
                n_state = eqs_pkg::ST_SUM;
            end
            eqs_pkg::ST_SUM: begin
                n_mhi = r_dhi * $signed({1'b0, r_phi[15:0]});
                n_qlo = r_blo + 32'(r_mlo >>> 16);
                n_state = eqs_pkg::ST_OUT;
            end
            // hold until the output register is free
            eqs_pkg::ST_OUT: begin
                n_qhi = r_bhi + 32'(r_mhi >>> 16);
                if (!r_ovalid || out_if.ready) begin
                    n_out = {r_qlo, n_qhi, 11'(r_fill), r_ovf};
                    n_ovalid = 1'b1;
                    n_fill = '0;
                    n_ovf = 1'b0;
                    n_state = eqs_pkg::ST_IDLE;
                end
            end
            default: n_state = eqs_pkg::ST_IDLE;
        endcase
    end
endmodule

// ===== rtl/edge_quantile_selector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_quantile_selector: top level
// Sorts a sample set into memory and reports interpolated edge quantiles.
//
//   channel  dir  payload
//   in_if    in   {last_sample, sample_value}
//   out_if   out  {lower_q, upper_q, sample_total, dropped_flag}
//   cfg      in   edge fraction write
//
// Each sample is accepted in IDLE, then sinks through the store: each moved
// entry costs one read (INS_RD) and one write (INS_CMP), and the sample is
// written into the hole before POS. A dropped sample goes from IDLE to POS.
// A last sample adds the reads of both neighbor pairs, two multiplies and the
// output load. Synchronous reset clears the count and flags; the store holds
// nothing until written. The result waits in an output register; a stalled
// output holds only the next set's end.
// ----------------------------------------------------------------------------
module edge_quantile_selector #(
    parameter int MAX_SAMPLES = eqs_pkg::MAX_SAMPLES
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata,
    eqs_stream_if.sink   in_if,
    eqs_stream_if.source out_if
);
    localparam int AW = $clog2(MAX_SAMPLES);
    logic [15:0]       r_edge;
    eqs_pkg::t_mem_req w_mem;
    logic [31:0]       w_rdata;

    // edge fraction register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge <= eqs_pkg::EDGE_RESET;
        end else if (i_cfg_we) begin
            r_edge <= i_cfg_wdata;
        end
    end

    eqs_ctrl #(.DEPTH(MAX_SAMPLES)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_edge_frac(r_edge),
        .in_if(in_if), .out_if(out_if), .o_mem(w_mem), .i_rdata(w_rdata)
    );

    eqs_sample_ram #(.DEPTH(MAX_SAMPLES)) u_ram (
        .i_clk(i_clk), .i_we(w_mem.wr_en), .i_waddr(w_mem.wr_addr[AW-1:0]),
        .i_wdata(w_mem.wr_data), .i_raddr(w_mem.rd_addr[AW-1:0]),
        .o_rdata(w_rdata)
    );
endmodule

// ===== tb/eqs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqs_checker: quantile predictor and result compare
// Watches the sample, result and edge width channels and keeps its own
// sorted copy of each sample set. On the last sample it works out the
// interpolated lower and upper edge quantiles, then compares every accepted
// result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module eqs_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    eqs_stream_if       in_ch,
    eqs_stream_if       out_ch,
    output int          o_fail_count,
    output int          o_pending
);
    typedef struct packed {
        logic [31:0] lower_q;
        logic [31:0] upper_q;
        logic [10:0] kept;
        logic        dropped;
    } t_quantiles;

    t_quantiles  quantile_fifo[$];
    longint      sorted_set[eqs_pkg::MAX_SAMPLES];
    int          set_fill;
    bit          set_overflow;
    logic [15:0] edge_frac;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s got %h want %h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    // type-7 interpolation at a 16.16 position over the sorted set
    function automatic longint interp_sorted(input longint pos, input int n);
        longint k;
        longint frac;
        longint base;
        k = pos >>> 16;
        frac = pos & 64'hFFFF;
        if (k >= n) k = n - 1;
        base = sorted_set[k];
        if (frac == 0 || k + 1 >= n) return base;
        return base + (((sorted_set[k + 1] - base) * frac) >>> 16);
    endfunction

    // add one sample and predict the quantiles on the last one
    task automatic absorb_sample(input logic [32:0] req);
        longint     v;
        int         i;
        longint     span;
        t_quantiles q;
        v = longint'($signed(req[31:0]));
        if (set_fill < eqs_pkg::MAX_SAMPLES) begin
            i = set_fill;
            while (i > 0 && sorted_set[i - 1] > v) begin
                sorted_set[i] = sorted_set[i - 1];
                i--;
            end
            sorted_set[i] = v;
            set_fill++;
        end else begin
            set_overflow = 1'b1;
        end
        if (req[32]) begin
            span = set_fill - 1;
            q.lower_q = 32'(interp_sorted(longint'(edge_frac) * span, set_fill));
            q.upper_q = 32'(interp_sorted((65536 - longint'(edge_frac)) * span,
                                          set_fill));
            q.kept    = 11'(set_fill);
            q.dropped = set_overflow;
            quantile_fifo.push_back(q);
            set_fill = 0;
            set_overflow = 1'b0;
        end
    endtask

    // compare one result with the oldest prediction
    task automatic check_result(input t_quantiles got);
        t_quantiles want;
        if (quantile_fifo.size() == 0) begin
            $display("%0t unexpected result %h", $realtime, got);
            o_fail_count++;
        end else begin
            want = quantile_fifo.pop_front();
            if (got.lower_q !== want.lower_q)
                report_mismatch("lower edge", got.lower_q, want.lower_q);
            if (got.upper_q !== want.upper_q)
                report_mismatch("upper edge", got.upper_q, want.upper_q);
            if (got.kept !== want.kept)
                report_mismatch("sample_total", 32'(got.kept), 32'(want.kept));
            if (got.dropped !== want.dropped)
                report_mismatch("dropped_flag", 32'(got.dropped), 32'(want.dropped));
        end
    endtask

    // monitor the channels at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            set_fill = 0;
            set_overflow = 1'b0;
            edge_frac = eqs_pkg::EDGE_RESET;
            o_fail_count = 0;
            quantile_fifo.delete();
        end else begin
            if (i_cfg_we) edge_frac = i_cfg_wdata;
            if (in_ch.valid && in_ch.ready) absorb_sample(in_ch.data);
            if (out_ch.valid && out_ch.ready) check_result(out_ch.data);
        end
        o_pending = quantile_fifo.size();
    end
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: edge quantile selector testbench
// Loads directed and random sample sets under several edge widths and idle
// patterns on both channels; the checker predicts and compares the results.
// ----------------------------------------------------------------------------
module tb;
    localparam int WATCHDOG_LIMIT = 40000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          quiet_cycles = 0;

    eqs_stream_if #(.WIDTH(33)) in_if ();
    eqs_stream_if #(.WIDTH(76)) out_if ();

    edge_quantile_selector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .in_if       (in_if),
        .out_if      (out_if)
    );

    eqs_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .in_ch        (in_if),
        .out_ch       (out_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side stalls
    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles with no accepted request or result
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL edge_quantile_selector");
            $finish;
        end
    end

    // offer one request and hold it until accepted
    task automatic send_sample(input logic [31:0] value, input logic last);
        if ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= {last, value};
        do @(negedge i_clk); while (!in_if.ready);
        @(posedge i_clk);
    endtask

    // drop valid, let every result out, then let the block settle
    task automatic drain;
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_edge(input logic [15:0] w);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // random set of n samples: values wide or clustered
    task automatic send_random_set(input int n);
        logic [31:0] v;
        int          style;
        style = $urandom_range(3);
        for (int i = 0; i < n; i++) begin
            case (style)
                0: v = $urandom;
                1: v = 32'($signed($urandom_range(200)) - 100) <<< 16;
                2: v = 32'($urandom_range(7));
                default: v = {{16{$urandom_range(1) == 1}}, 16'($urandom)};
            endcase
            send_sample(v, i == n - 1);
        end
    endtask

    function automatic int pick_set_size;
        if ($urandom_range(19) == 0) return $urandom_range(40, 120);
        return $urandom_range(1, 12);
    endfunction

    int          sent;
    int          n;
    logic [15:0] w;

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        in_if.valid    = 1'b0;
        in_if.data     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed sets at the reset edge width
        send_sample(32'h7FFFFFFF, 1'b1);
        send_sample(32'h80000000, 1'b1);
        send_sample(32'h7FFFFFFF, 1'b0);
        send_sample(32'h80000000, 1'b1);
        send_sample(32'h00010000, 1'b0);
        send_sample(32'hFFFF0000, 1'b0);
        send_sample(32'h00010000, 1'b0);
        send_sample(32'h00000000, 1'b1);

        // lower edge at zero, exact positions
        write_edge(16'd0);
        send_sample(32'h80000000, 1'b0);
        send_sample(32'h00000005, 1'b0);
        send_sample(32'h7FFFFFFF, 1'b1);

        // median, then edge past one half
        write_edge(16'd32768);
        send_sample(32'h80000000, 1'b0);
        send_sample(32'h7FFFFFFF, 1'b1);
        write_edge(16'hFFFF);
        send_sample(32'hFFFFFFFF, 1'b0);
        send_sample(32'h7FFFFFFF, 1'b0);
        send_sample(32'h80000000, 1'b1);

        // random phases with varied edge widths and idle patterns
        sent = 0;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            case ($urandom_range(4))
                0: w = 16'd0;
                1: w = 16'd32768;
                2: w = 16'hFFFF;
                default: w = 16'($urandom);
            endcase
            write_edge(w);
            while (sent < (phase + 1) * 54) begin
                n = pick_set_size();
                send_random_set(n);
                sent += n;
            end
        end

        drain();
        if (fail_count == 0)
            $display("PASS edge_quantile_selector");
        else
            $display("FAIL edge_quantile_selector");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/eqs_pkg.sv
rtl/eqs_stream_if.sv
rtl/eqs_sample_ram.sv
rtl/eqs_ctrl.sv
rtl/edge_quantile_selector.sv
tb/eqs_checker.sv
tb/tb.sv
